### sv/tlbpt_pkg.sv
`timescale 1ns / 1ps
package tlbpt_pkg;

  localparam int OFFSET_BITS = 8;
  localparam int PAGE_COUNT  = 256;
  localparam int TLB_DEPTH   = 16;
  localparam int FRAME_COUNT = 128;

  localparam int PAGE_BITS  = $clog2(PAGE_COUNT);
  localparam int TLB_BITS   = $clog2(TLB_DEPTH);
  localparam int FRAME_BITS = $clog2(FRAME_COUNT);

  localparam int VA_W        = 16;
  localparam int PHYS_W      = 15;
  localparam int FRAME_OUT_W = 7;
  localparam int PAGE_OUT_W  = 8;
  localparam int STAMP_W     = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_PT,
    S_FSCAN,
    S_INSTALL,
    S_TSCAN,
    S_FILL
  } state_t;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic pt_check;
    logic scan_init;
    logic scan_step;
    logic install;
    logic tscan_init;
    logic tscan_step;
    logic fill;
  } dp_cmd_t;

  typedef struct packed {
    logic tlb_match;
    logic pt_hit;
    logic scan_done;
    logic tscan_done;
  } dp_sts_t;

endpackage

### sv/tlbpt_ctrl.sv
`timescale 1ns / 1ps
module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_LOOKUP;
      S_LOOKUP:  state_next = sts.tlb_match ? S_IDLE : S_PT;
      S_PT:      state_next = sts.pt_hit ? S_TSCAN : S_FSCAN;
      S_FSCAN:   if (sts.scan_done) state_next = S_INSTALL;
      S_INSTALL: state_next = S_TSCAN;
      S_TSCAN:   if (sts.tscan_done) state_next = S_FILL;
      S_FILL:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cmd.accept = start;
      S_LOOKUP: cmd.lookup = 1'b1;
      S_PT: begin
        cmd.pt_check   = 1'b1;
        cmd.tscan_init = sts.pt_hit;
        cmd.scan_init  = !sts.pt_hit;
      end
      S_FSCAN:  cmd.scan_step = 1'b1;
      S_INSTALL: begin
        cmd.install    = 1'b1;
        cmd.tscan_init = 1'b1;
      end
      S_TSCAN:  cmd.tscan_step = 1'b1;
      S_FILL:   cmd.fill = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

### sv/tlbpt_datapath.sv
`timescale 1ns / 1ps
module tlbpt_datapath
  import tlbpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [VA_W-1:0]        virt_address,
  output logic                   done,
  output logic [PHYS_W-1:0]      phys_address,
  output logic [FRAME_OUT_W-1:0] frame_index,
  output logic                   tlb_hit,
  output logic                   fault,
  output logic                   evict_valid,
  output logic [PAGE_OUT_W-1:0]  evicted_page
);

  logic [STAMP_W-1:0]     use_clock;
  logic [PAGE_BITS-1:0]   page_r;
  logic [OFFSET_BITS-1:0] offs_r;
  logic [FRAME_BITS-1:0]  frame_r;
  logic                   fault_r;
  logic                   evict_r;
  logic [PAGE_BITS-1:0]   evpage_r;

  logic                  tlb_valid [TLB_DEPTH];
  logic [PAGE_BITS-1:0]  tlb_page  [TLB_DEPTH];
  logic [FRAME_BITS-1:0] tlb_frame [TLB_DEPTH];
  logic [STAMP_W-1:0]    tlb_stamp [TLB_DEPTH];

  logic [PAGE_COUNT-1:0] pt_valid;
  logic [FRAME_BITS-1:0] pt_mem [PAGE_COUNT];
  logic [FRAME_BITS-1:0] pt_rdata;

  logic [STAMP_W-1:0]     fs_mem [FRAME_COUNT];
  logic [STAMP_W-1:0]     fs_rdata;
  logic                   fs_we;
  logic [FRAME_BITS-1:0]  fs_waddr;
  logic [FRAME_COUNT-1:0] owner_valid;
  logic [PAGE_BITS-1:0]   owner_mem [FRAME_COUNT];
  logic [PAGE_BITS-1:0]   owner_rdata;

  logic [FRAME_BITS:0]   sc;
  logic                  pend;
  logic [FRAME_BITS-1:0] rd_idx;
  logic [STAMP_W-1:0]    best;
  logic [FRAME_BITS-1:0] victim;
  logic [STAMP_W-1:0]    scan_val;

  logic [TLB_BITS:0]     ti;
  logic [TLB_BITS-1:0]   ti_idx;
  logic                  tfree;
  logic [STAMP_W-1:0]    tbest;
  logic [TLB_BITS-1:0]   tvict;

  logic                  match;
  logic [TLB_BITS-1:0]   midx;
  logic [FRAME_BITS-1:0] out_frame;
  logic                  emit;

  // lowest matching valid entry wins
  always_comb begin
    match = 1'b0;
    midx  = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (tlb_valid[i] && tlb_page[i] == page_r) begin
        match = 1'b1;
        midx  = TLB_BITS'(i);
      end
    end
  end

  assign scan_val = owner_valid[rd_idx] ? fs_rdata : '0;
  assign ti_idx   = ti[TLB_BITS-1:0];

  assign sts.tlb_match  = match;
  assign sts.pt_hit     = pt_valid[page_r];
  assign sts.scan_done  = (sc == (FRAME_BITS+1)'(FRAME_COUNT)) && !pend;
  assign sts.tscan_done = (ti == (TLB_BITS+1)'(TLB_DEPTH));

  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = victim;
    priority if (cmd.lookup && match) begin
      fs_we    = 1'b1;
      fs_waddr = tlb_frame[midx];
    end else if (cmd.pt_check && pt_valid[page_r]) begin
      fs_we    = 1'b1;
      fs_waddr = pt_rdata;
    end else if (cmd.install) begin
      fs_we    = 1'b1;
      fs_waddr = victim;
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= use_clock;
    fs_rdata <= fs_mem[sc[FRAME_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.install) pt_mem[page_r] <= victim;
    pt_rdata <= pt_mem[page_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.install) owner_mem[victim] <= page_r;
    owner_rdata <= owner_mem[victim];
  end

  assign emit      = (cmd.lookup && match) || cmd.fill;
  assign out_frame = cmd.lookup ? tlb_frame[midx] : frame_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      phys_address <= PHYS_W'({out_frame, offs_r});
      frame_index  <= FRAME_OUT_W'(out_frame);
      tlb_hit      <= cmd.lookup;
      fault        <= fault_r;
      evict_valid  <= evict_r;
      evicted_page <= PAGE_OUT_W'(evpage_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock   <= '0;
      pt_valid    <= '0;
      owner_valid <= '0;
      done        <= 1'b0;
      pend        <= 1'b0;
      sc          <= '0;
      ti          <= '0;
      tfree       <= 1'b0;
      for (int i = 0; i < TLB_DEPTH; i++) tlb_valid[i] <= 1'b0;
    end else begin
      done <= emit;
      if (cmd.accept) begin
        use_clock <= use_clock + 1'b1;
        page_r    <= PAGE_BITS'(virt_address >> OFFSET_BITS);
        offs_r    <= virt_address[OFFSET_BITS-1:0];
        fault_r   <= 1'b0;
        evict_r   <= 1'b0;
        evpage_r  <= '0;
      end
      if (cmd.lookup && match) tlb_stamp[midx] <= use_clock;
      if (cmd.pt_check && pt_valid[page_r]) frame_r <= pt_rdata;

      // frame lru scan, one stamp read per cycle
      if (cmd.scan_init) begin
        sc   <= '0;
        pend <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (sc != (FRAME_BITS+1)'(FRAME_COUNT)) begin
          sc     <= sc + 1'b1;
          pend   <= 1'b1;
          rd_idx <= sc[FRAME_BITS-1:0];
        end else begin
          pend <= 1'b0;
        end
        if (pend && (rd_idx == '0 || scan_val < best)) begin
          best   <= scan_val;
          victim <= rd_idx;
        end
      end

      if (cmd.install) begin
        frame_r <= victim;
        fault_r <= 1'b1;
        if (owner_valid[victim]) begin
          evict_r  <= 1'b1;
          evpage_r <= owner_rdata;
          pt_valid[owner_rdata] <= 1'b0;
          for (int i = 0; i < TLB_DEPTH; i++) begin
            if (tlb_valid[i] && tlb_page[i] == owner_rdata) tlb_valid[i] <= 1'b0;
          end
        end
        owner_valid[victim] <= 1'b1;
        pt_valid[page_r]    <= 1'b1;
      end

      // tlb victim scan: first free entry, else oldest stamp
      if (cmd.tscan_init) begin
        ti    <= '0;
        tfree <= 1'b0;
      end
      if (cmd.tscan_step && ti != (TLB_BITS+1)'(TLB_DEPTH)) begin
        ti <= ti + 1'b1;
        if (!tfree) begin
          if (!tlb_valid[ti_idx]) begin
            tfree <= 1'b1;
            tvict <= ti_idx;
          end else if (ti_idx == '0 || tlb_stamp[ti_idx] < tbest) begin
            tbest <= tlb_stamp[ti_idx];
            tvict <= ti_idx;
          end
        end
      end

      if (cmd.fill) begin
        tlb_valid[tvict] <= 1'b1;
        tlb_page[tvict]  <= page_r;
        tlb_frame[tvict] <= frame_r;
        tlb_stamp[tvict] <= use_clock;
      end
    end
  end

endmodule

### sv/tlb_page_table_lru_translate_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// request   in         start && !busy      virt_address
// result    out        done (one cycle)    phys_address, frame_index, tlb_hit,
//                                          fault, evict_valid, evicted_page
//
// tlb hit: the lookup state emits the result, which is registered into done
// tlb miss, page resident: page table check, then the serial tlb victim scan and the fill
// page fault: page table check, then the frame stamp scan through the single
//   stamp memory port, the install, then the tlb victim scan and the fill
// synchronous reset clears all valid bits at once; no clearing pass
// one request at a time; done may coincide with the next accept
module tlb_page_table_lru_translate_unit
  import tlbpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VA_W-1:0]        virt_address,
  output logic                   done,
  output logic [PHYS_W-1:0]      phys_address,
  output logic [FRAME_OUT_W-1:0] frame_index,
  output logic                   tlb_hit,
  output logic                   fault,
  output logic                   evict_valid,
  output logic [PAGE_OUT_W-1:0]  evicted_page
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tlbpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tlbpt_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .virt_address (virt_address),
    .done         (done),
    .phys_address (phys_address),
    .frame_index  (frame_index),
    .tlb_hit      (tlb_hit),
    .fault        (fault),
    .evict_valid  (evict_valid),
    .evicted_page (evicted_page)
  );

endmodule

### sv/tlbpt_checker.sv
`timescale 1ns / 1ps
module tlbpt_checker
  import tlbpt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [PHYS_W-1:0]      phys_address,
  input logic [FRAME_OUT_W-1:0] frame_index,
  input logic                   tlb_hit,
  input logic                   fault,
  input logic                   evict_valid,
  input logic [PAGE_OUT_W-1:0]  evicted_page
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_hit_no_fault: assert property (@(posedge clk) disable iff (rst)
    done && tlb_hit |-> !fault && !evict_valid)
    else $error("tlb hit reported with fault");

  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    done && !fault |-> !evict_valid && evicted_page == '0)
    else $error("eviction without fault");

  a_phys_frame: assert property (@(posedge clk) disable iff (rst)
    done |-> phys_address[PHYS_W-1:OFFSET_BITS] == frame_index)
    else $error("physical address disagrees with frame");

endmodule

bind tlb_page_table_lru_translate_unit tlbpt_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .phys_address (phys_address),
  .frame_index  (frame_index),
  .tlb_hit      (tlb_hit),
  .fault        (fault),
  .evict_valid  (evict_valid),
  .evicted_page (evicted_page)
);
